FILE: rtl/assert_macros.svh
// Assertion helpers used by twm_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/twm_pkg.sv
package twm_pkg;

  localparam logic [31:0] SEED_RESET = 32'h2a80ce30;
  localparam logic [31:0] MUL_A      = 32'd3141592621;
  localparam logic [31:0] MUL_B      = 32'd1568397607;
  localparam logic [31:0] MUL_C      = 32'd2435386481;

  // Fraction scaling: 65536/4095 = 16 + 16/4095, so only round(16m/4095)
  // needs a division. That is floor(n/8190) with n = 32m + 4095 < 2^18,
  // done as a multiply by ceil(2^31/8190) and a shift by 31.
  localparam int          FRAC_W      = 12;
  localparam logic [17:0] FRAC_DIV    = 18'd4095;
  localparam logic [18:0] RECIP_M     = 19'd262209;
  localparam int          RECIP_SHIFT = 31;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_RAW    = 2'd0,
    OP_RANGE  = 2'd1,
    OP_UNIT   = 2'd2,
    OP_SIGNED = 2'd3
  } twm_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX_C,
    ST_SHAPE
  } twm_state_t;

  // One queued request: result form, low bound and precomputed span.
  typedef struct packed {
    twm_op_t     op;
    logic [15:0] range_low;
    logic [31:0] span;
  } twm_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } twm_qstat_t;

endpackage

FILE: rtl/twm_front.sv
module twm_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic [15:0]         in_range_low,
  input  logic [15:0]         in_range_high,
  input  twm_pkg::twm_qstat_t q_stat,
  output logic                push,
  output twm_pkg::twm_item_t  item
);
  import twm_pkg::*;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  // The span wraps modulo 2^32 when the low bound is above the high bound.
  always_comb begin
    item.op        = twm_op_t'(in_op);
    item.range_low = in_range_low;
    item.span      = {16'd0, in_range_high} + 32'd1 - {16'd0, in_range_low};
  end

endmodule

FILE: rtl/twm_queue.sv
module twm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  twm_pkg::twm_item_t  push_item,
  input  logic                pop,
  output twm_pkg::twm_item_t  head_item,
  output twm_pkg::twm_qstat_t q_stat
);
  import twm_pkg::*;

  twm_item_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]    count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_item    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/twm_back.sv
module twm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data,
  input  twm_pkg::twm_qstat_t q_stat,
  input  twm_pkg::twm_item_t  head_item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_raw_word,
  output logic [15:0]         out_ranged_value,
  output logic signed [17:0]  out_fraction_q16
);
  import twm_pkg::*;

  twm_state_t  state_r, state_nxt;
  logic [31:0] a_r, a_nxt;
  logic [31:0] b_r, b_nxt;
  logic [31:0] c_r, c_nxt;
  twm_item_t   item_r;

  logic               out_valid_r;
  logic [31:0]        raw_r;
  logic [15:0]        ranged_r, ranged_nxt;
  logic signed [17:0] frac_r, frac_nxt;

  logic out_free;
  logic shape_fire;

  // Shaping datapath signals.
  logic [FRAC_W-1:0] r12;
  logic [12:0]       twice_r;
  logic [12:0]       m_wide;
  logic [FRAC_W-1:0] m;
  logic              neg;
  logic              zero_frac;
  logic [17:0]       n;
  logic [36:0]       recip_prod;
  logic [5:0]        q;
  logic [16:0]       mag;
  logic [31:0]       range_prod;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (!q_stat.empty) state_nxt = ST_MIX_C;
      ST_MIX_C: state_nxt = ST_SHAPE;
      ST_SHAPE: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    shape_fire = 1'b0;
    case (state_r)
      ST_IDLE:  pop = !q_stat.empty;
      ST_SHAPE: shape_fire = out_free;
      default: begin
        pop        = 1'b0;
        shape_fire = 1'b0;
      end
    endcase
  end

  // State word updates: A and B together, then C from the new A and B.
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    if (cfg_wr_en) begin
      a_nxt = cfg_wr_data;
      b_nxt = '0;
      c_nxt = '0;
    end else if (pop) begin
      a_nxt = (a_r + 32'd1) * MUL_A;
      b_nxt = b_r ^ ((c_r >> 5) * MUL_B);
    end else if (state_r == ST_MIX_C) begin
      c_nxt = c_r ^ (((b_r >> 7) + a_r) * MUL_C);
    end
  end

  // Result shaping from the new C word.
  always_comb begin
    r12       = c_r[FRAC_W-1:0];
    twice_r   = {r12, 1'b0};
    zero_frac = 1'b0;
    if (item_r.op == OP_SIGNED) begin
      if (twice_r >= 13'(FRAC_DIV)) begin
        m_wide = twice_r - 13'(FRAC_DIV);
        neg    = 1'b0;
      end else begin
        m_wide = 13'(FRAC_DIV) - twice_r;
        neg    = 1'b1;
      end
      zero_frac = (r12 == '0);
    end else begin
      m_wide = {1'b0, r12};
      neg    = 1'b0;
    end
    m          = m_wide[FRAC_W-1:0];
    n          = {1'b0, m, 5'd0} + FRAC_DIV;
    recip_prod = 37'(n) * 37'(RECIP_M);
    q          = recip_prod[36:RECIP_SHIFT];
    mag        = {1'b0, m, 4'd0} + 17'(q);
    range_prod = 32'(c_r[15:0]) * item_r.span;

    ranged_nxt = '0;
    frac_nxt   = '0;
    case (item_r.op)
      OP_RAW: begin
        ranged_nxt = '0;
        frac_nxt   = '0;
      end
      OP_RANGE: ranged_nxt = range_prod[31:16] + item_r.range_low;
      OP_UNIT:  frac_nxt = $signed({1'b0, mag});
      OP_SIGNED: begin
        if (zero_frac) begin
          frac_nxt = '0;
        end else if (neg) begin
          frac_nxt = -$signed({1'b0, mag});
        end else begin
          frac_nxt = $signed({1'b0, mag});
        end
      end
      default: begin
        ranged_nxt = '0;
        frac_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      a_r         <= SEED_RESET;
      b_r         <= '0;
      c_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      c_r     <= c_nxt;
      if (shape_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= head_item;
    end
    if (shape_fire) begin
      raw_r    <= c_r;
      ranged_r <= ranged_nxt;
      frac_r   <= frac_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_raw_word     = raw_r;
  assign out_ranged_value = ranged_r;
  assign out_fraction_q16 = frac_r;

endmodule

FILE: rtl/three_word_multiply_rng.sv
// Three-word multiplicative random generator. Each accepted item draws one
// new 32-bit word from three state words and returns it together with a
// shaped form chosen by in_op: the raw word, a value in an inclusive 16-bit
// range, or a signed Q1.16 fraction in [0,1] or [-1,+1]. A write on the
// configuration port reloads the first word with the seed and clears the
// other two; it must only happen while no item is in flight. The back-end
// sequencer works on one item at a time: it pops the item and does the two
// independent multiplies of words A and B, then the add and multiply of
// word C, then the range or fraction multiply that shapes the result, where
// it waits while the previous result is not yet taken. Only then does it
// pop the next item. A two-item queue sits between the input side and the
// sequencer, and the result has a register of its own, so new items are
// taken while a finished result waits for out_ready.
module three_word_multiply_rng (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [15:0]        in_range_low,
  input  logic [15:0]        in_range_high,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_raw_word,
  output logic [15:0]        out_ranged_value,
  output logic signed [17:0] out_fraction_q16
);
  import twm_pkg::*;

  twm_qstat_t q_stat;
  twm_item_t  push_item;
  twm_item_t  head_item;
  logic       push;
  logic       pop;

  // The front end checks for queue room and precomputes the range span.
  twm_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .q_stat        (q_stat),
    .push          (push),
    .item          (push_item)
  );

  // The queue decouples the input handshake from the sequencer.
  twm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  // The back end owns the state words, draws the word and shapes the result.
  twm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .q_stat           (q_stat),
    .head_item        (head_item),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_raw_word     (out_raw_word),
    .out_ranged_value (out_ranged_value),
    .out_fraction_q16 (out_fraction_q16)
  );

endmodule

FILE: rtl/twm_checker.sv
`include "assert_macros.svh"

module twm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [31:0]        out_raw_word,
  input logic [15:0]        out_ranged_value,
  input logic signed [17:0] out_fraction_q16
);

  // A waiting result stays offered.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out_valid dropped")

  // A waiting result keeps its payload.
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_raw_word) && $stable(out_ranged_value) && $stable(out_fraction_q16), "stalled result changed")

  // The fraction never leaves the closed interval from minus one to one.
  `ASSERT_IMPLIES(a_frac_range, clk, rst_n, out_valid, (out_fraction_q16 <= 18'sd65536) && (out_fraction_q16 >= -18'sd65536), "fraction out of range")

  // A range result and a fraction never appear in the same item.
  `ASSERT_IMPLIES(a_one_form, clk, rst_n, out_valid && (out_ranged_value != 16'd0), out_fraction_q16 == 18'sd0, "range and fraction both set")

endmodule

bind three_word_multiply_rng twm_checker u_checker (.*);

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import twm_pkg::*;

  // One expected result item, at the widths of the result ports.
  typedef struct {
    logic [31:0]        raw;
    logic [15:0]        ranged;
    logic signed [17:0] frac;
  } draw_result_t;

  // Keeps a private copy of the generator state, works out the result of
  // every accepted request and compares the block's results against them.
  class rng_scoreboard;
    logic [31:0]  cur_seed;
    logic [31:0]  mix_a, mix_b, mix_c;
    draw_result_t pending_draws[$];
    int           n_errors;
    int           n_checked;
    int           n_loads;
    int           per_op[4];

    function new();
      reload(SEED_RESET);
      n_loads = 0;
    endfunction

    // A seed write puts the seed in the first word and clears the other two.
    function void reload(logic [31:0] value);
      cur_seed = value;
      mix_a = value;
      mix_b = '0;
      mix_c = '0;
      n_loads++;
    endfunction

    // Advances the three words by one draw and returns the new third word.
    // The middle word uses the third word from before this draw, the third
    // word uses the new first and middle words.
    static function logic [31:0] draw_word(inout logic [31:0] a, inout logic [31:0] b,
                                           inout logic [31:0] c);
      a = (a + 32'd1) * MUL_A;
      b ^= (c >> 5) * MUL_B;
      c ^= ((b >> 7) + a) * MUL_C;
      return c;
    endfunction

    // round(m * 65536 / 4095) for non-negative m, halves rounded up.
    static function longint unsigned scale_q16(longint unsigned m);
      return ((m << 16) * 2 + 64'd4095) / 64'd8190;
    endfunction

    function void note_request(twm_op_t op, logic [15:0] lo, logic [15:0] hi);
      draw_result_t    res;
      logic [31:0]     word;
      logic [31:0]     span;
      logic [31:0]     prod;
      logic [11:0]     r;
      longint unsigned q;

      word = draw_word(mix_a, mix_b, mix_c);
      r = word[11:0];
      res.raw = word;
      res.ranged = '0;
      res.frac = '0;
      case (op)
        OP_RANGE: begin
          // The span wraps modulo 2^32 when the bounds are swapped; the
          // final sum is cut back to 16 bits.
          span = {16'd0, hi} + 32'd1 - {16'd0, lo};
          prod = {16'd0, word[15:0]} * span;
          res.ranged = 16'((prod >> 16) + {16'd0, lo});
        end
        OP_UNIT: begin
          res.frac = 18'(scale_q16(longint'(r)));
        end
        OP_SIGNED: begin
          // A zero draw gives zero rather than minus one.
          if (r != 12'd0) begin
            if (2 * int'(r) >= 4095) begin
              q = scale_q16(longint'(2 * int'(r) - 4095));
              res.frac = 18'(q);
            end else begin
              q = scale_q16(longint'(4095 - 2 * int'(r)));
              res.frac = 18'(-longint'(q));
            end
          end
        end
        default: ;
      endcase
      per_op[op]++;
      pending_draws.push_back(res);
    endfunction

    function void check_result(logic [31:0] raw, logic [15:0] ranged,
                               logic signed [17:0] frac);
      draw_result_t exp_res;

      if (pending_draws.size() == 0) begin
        $error("Result item with nothing expected: raw %h ranged %h fraction %0d",
               raw, ranged, frac);
        n_errors++;
        return;
      end
      exp_res = pending_draws.pop_front();
      n_checked++;
      if (raw !== exp_res.raw) begin
        $error("raw_word: expected %h, got %h", exp_res.raw, raw);
        n_errors++;
      end
      if (ranged !== exp_res.ranged) begin
        $error("ranged_value: expected %0d, got %0d", exp_res.ranged, ranged);
        n_errors++;
      end
      if (frac !== exp_res.frac) begin
        $error("fraction_q16: expected %0d, got %0d", exp_res.frac, frac);
        n_errors++;
      end
    endfunction

    function int pending();
      return pending_draws.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [31:0]        cfg_wr_data;
  logic               in_valid;
  logic               in_ready;
  twm_op_t            in_op;
  logic [15:0]        in_range_low;
  logic [15:0]        in_range_high;
  logic               out_valid;
  logic               out_ready;
  logic [31:0]        out_raw_word;
  logic [15:0]        out_ranged_value;
  logic signed [17:0] out_fraction_q16;

  rng_scoreboard sb = new();

  // Percent of cycles in which the sender holds back an item and the
  // receiver refuses a result. The main sequence changes these per phase.
  int send_idle_pct;
  int recv_idle_pct;

  three_word_multiply_rng uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_range_low     (in_range_low),
    .in_range_high    (in_range_high),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_raw_word     (out_raw_word),
    .out_ranged_value (out_ranged_value),
    .out_fraction_q16 (out_fraction_q16)
  );

  always #5 clk = ~clk;

  // Both handshakes are sampled at the rising edge, before the block's own
  // registers move, so the monitor sees the values that the edge acts on.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_request(in_op, in_range_low, in_range_high);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_raw_word, out_ranged_value, out_fraction_q16);
      end
    end
  end

  // The receiver decides anew at each falling edge whether it takes a result.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Offers one item and returns at the falling edge after it was accepted.
  // Valid is only dropped during a sender gap, and then in a step of its own,
  // so it is never lowered and raised within the same time step.
  task automatic send_item(twm_op_t op, logic [15:0] lo, logic [15:0] hi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_range_low <= lo;
    in_range_high <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random request. Most ranges are well ordered, some use the extreme
  // bounds and the rest are arbitrary, which includes swapped bounds.
  task automatic send_random_item();
    int          kind;
    logic [15:0] x, y;

    kind = $urandom_range(0, 99);
    x = 16'($urandom);
    y = 16'($urandom);
    if (kind < 10) begin
      x = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      y = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
    end else if (kind < 80 && x > y) begin
      {x, y} = {y, x};
    end
    send_item(twm_op_t'($urandom_range(0, 3)), x, y);
  endtask

  // Waits until every expected result has come back, then lets the
  // pipeline settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Seed writes only happen while the block holds no item.
  task automatic write_seed(logic [31:0] value);
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.reload(value);
  endtask

  // Searches for a seed whose first draw has the given low twelve bits, so
  // that the fraction forms can be hit at their end points on purpose.
  function automatic logic [31:0] seed_for_low_bits(logic [11:0] want);
    logic [31:0] s, a, b, c, w;

    do begin
      s = $urandom;
      a = s;
      b = '0;
      c = '0;
      w = rng_scoreboard::draw_word(a, b, c);
    end while (w[11:0] != want);
    return s;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_random_item();
  endtask

  initial begin
    logic [31:0] zero_seed;
    logic [31:0] top_seed;

    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_op = OP_RAW;
    in_range_low = '0;
    in_range_high = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed items from the reset seed: every form of result, the field
    // extremes, the full range, a single-value range and swapped bounds.
    send_item(OP_RAW, 16'h0000, 16'h0000);
    send_item(OP_RAW, 16'hffff, 16'hffff);
    send_item(OP_RANGE, 16'h0000, 16'hffff);
    send_item(OP_RANGE, 16'h0000, 16'h0000);
    send_item(OP_RANGE, 16'hffff, 16'hffff);
    send_item(OP_RANGE, 16'hffff, 16'h0000);
    send_item(OP_RANGE, 16'd40000, 16'd100);
    send_item(OP_RANGE, 16'd1000, 16'd1000);
    send_item(OP_RANGE, 16'd1, 16'd65534);
    send_item(OP_UNIT, 16'h5555, 16'haaaa);
    send_item(OP_SIGNED, 16'haaaa, 16'h5555);

    // Fractions at their end points: a draw whose low bits are all zero
    // gives zero in both forms, all ones gives plus one in both forms.
    zero_seed = seed_for_low_bits(12'h000);
    top_seed = seed_for_low_bits(12'hfff);
    wait_drained();
    write_seed(zero_seed);
    send_item(OP_SIGNED, 16'h0000, 16'h0000);
    wait_drained();
    write_seed(zero_seed);
    send_item(OP_UNIT, 16'h0000, 16'h0000);
    wait_drained();
    write_seed(top_seed);
    send_item(OP_SIGNED, 16'h0000, 16'h0000);
    wait_drained();
    write_seed(top_seed);
    send_item(OP_UNIT, 16'h0000, 16'h0000);
    wait_drained();

    // First random phase: seed zero, the receiver stalls more than the
    // sender idles, so results back up behind the output register.
    write_seed(32'h0000_0000);
    send_idle_pct = 24;
    recv_idle_pct = 56;
    run_random(600);
    wait_drained();

    // Second phase: all-ones seed and the stall pattern swapped. Halfway
    // through, the sender holds off until the block has emptied.
    write_seed(32'hffff_ffff);
    send_idle_pct = 56;
    recv_idle_pct = 24;
    run_random(300);
    wait_drained();
    run_random(300);
    wait_drained();

    // Last phase: a random seed with both sides running flat out.
    write_seed($urandom);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(600);
    wait_drained();

    $display("Checked %0d results: %0d raw, %0d range, %0d unit, %0d signed.",
             sb.n_checked, sb.per_op[OP_RAW], sb.per_op[OP_RANGE],
             sb.per_op[OP_UNIT], sb.per_op[OP_SIGNED]);
    $display("Seed loads: %0d, with three stall patterns and fraction end points.",
             sb.n_loads);
    if (sb.n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Safety net in case the block stops answering handshakes.
  initial begin
    #2000000;
    $display("Timeout with %0d results still outstanding.", sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
